[rtl/mfps_pkg.sv]
// Shared constants for the minimum falling path sum block.
`timescale 1ns / 1ps
`default_nettype none

package mfps_pkg;

  // Default build sizes
  localparam int MAX_SIZE_DEF   = 128;
  localparam int CELL_WIDTH_DEF = 16;

  // Configuration register width
  localparam int CFG_WIDTH = 8;

  // Result field and its byte-padded stream width
  localparam int SUM_WIDTH   = 23;
  localparam int OUT_TDATA_W = ((SUM_WIDTH + 7) / 8) * 8;
  localparam int OUT_PAD     = OUT_TDATA_W - SUM_WIDTH;

endpackage

`default_nettype wire

[rtl/mfps_result_q.sv]
// Two-entry result queue: output register plus skid register.
`timescale 1ns / 1ps
`default_nettype none

module mfps_result_q (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  input  wire logic [mfps_pkg::SUM_WIDTH-1:0] push_data,
  output logic                                room,
  output logic                                out_valid,
  output logic [mfps_pkg::SUM_WIDTH-1:0]      out_data,
  input  wire logic                           out_ready
);

  logic                           skid_valid;
  logic [mfps_pkg::SUM_WIDTH-1:0] skid_data;
  logic                           pop;
  logic [1:0]                     count_next;

  assign pop = out_valid && out_ready;

  // Room for one more result after this edge's push and pop
  assign count_next = 2'({1'b0, out_valid}) + 2'({1'b0, skid_valid})
                    + 2'({1'b0, push}) - 2'({1'b0, pop});
  assign room = (count_next < 2'd2);

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid  <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Data path
  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data  <= skid_valid ? skid_data : push_data;
      skid_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

`ifndef SYNTHESIS
  // A push into a full, stalled queue would drop a result
  assert property (@(posedge clk) disable iff (rst)
    (push && out_valid && !out_ready) |-> !skid_valid)
    else $error("result queue overflow");

  // Skid entry never sits behind an empty output register
  assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid with empty output register");

  // A waiting result holds its data until it is taken
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire

[rtl/min_falling_path_sum.sv]
// Minimum falling path sum over a streamed square matrix, top level.
//
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+-------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | tdata: cell_value (signed)
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata: min_sum (signed)
//  cfg       | in        | cfg_wr_en                     | cfg_wr_data: matrix_size
//
// One cell per cycle: a cell is accepted, its right neighbor read from the row
// memory in the same cycle, and its cost formed and written back the next cycle.
// The row memory has one read and one write port; a sliding window holds the
// other two neighbors. Only a matrix's final cell can stall, when two results wait.
// Reset (rst, synchronous) sets the size to 1 and restarts. Row memory contents
// are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module min_falling_path_sum #(
  parameter int MAX_SIZE   = mfps_pkg::MAX_SIZE_DEF,
  parameter int CELL_WIDTH = mfps_pkg::CELL_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration
  input  wire logic                                 cfg_wr_en,
  input  wire logic [mfps_pkg::CFG_WIDTH-1:0]       cfg_wr_data,   // matrix_size
  // cell stream
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [((CELL_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // [CELL_WIDTH-1:0] cell_value
  // result stream
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [mfps_pkg::OUT_TDATA_W-1:0]          m_axis_tdata   // [22:0] min_sum
);

  localparam int IDX_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int COST_W = CELL_WIDTH + IDX_W;
  localparam int EXT_W  = (COST_W > mfps_pkg::SUM_WIDTH) ? COST_W : mfps_pkg::SUM_WIDTH;

  // Size and position
  logic [IDX_W-1:0] size_last;
  logic [IDX_W-1:0] cfg_size_last;
  logic [31:0]      size_req;
  logic [IDX_W-1:0] col;
  logic [IDX_W-1:0] row;

  // Accept stage
  logic             s_accept;
  logic             last_col;
  logic             last_row;
  logic             next_final;
  logic [IDX_W-1:0] rd_addr;

  // Compute stage
  logic                         b_valid;
  logic signed [CELL_WIDTH-1:0] b_cell;
  logic [IDX_W-1:0]             b_col;
  logic                         b_first_row;
  logic                         b_last_row;
  logic                         b_final;
  logic                         b_has_left;
  logic                         b_has_right;

  // Row memory, forwarding and neighbor window
  logic signed [COST_W-1:0] row_mem [MAX_SIZE];
  logic signed [COST_W-1:0] mem_q;
  logic                     fwd;
  logic signed [COST_W-1:0] fwd_data;
  logic signed [COST_W-1:0] rd_value;
  logic signed [COST_W-1:0] win_cur;
  logic signed [COST_W-1:0] win_left;

  // Cost and running minimum
  logic signed [COST_W-1:0] best;
  logic signed [COST_W-1:0] cost;
  logic signed [COST_W-1:0] rmin;
  logic signed [COST_W-1:0] rmin_new;
  logic signed [EXT_W-1:0]  rmin_ext;

  // Result queue
  logic                           q_push;
  logic [mfps_pkg::SUM_WIDTH-1:0] q_push_data;
  logic                           q_room;
  logic [mfps_pkg::SUM_WIDTH-1:0] q_data;

  // Clamp the written size to 1..MAX_SIZE, stored as size - 1
  always_comb begin
    size_req = 32'(cfg_wr_data);
    if (size_req == 32'd0) size_req = 32'd1;
    if (size_req > 32'(MAX_SIZE)) size_req = 32'(MAX_SIZE);
    cfg_size_last = IDX_W'(size_req - 32'd1);
  end

  // Position decode for the next cell
  assign last_col   = (col == size_last);
  assign last_row   = (row == size_last);
  assign next_final = last_col && last_row;
  assign rd_addr    = last_col ? '0 : IDX_W'(col + 1'b1);

  // Only a final cell waits, for room in the result queue
  assign s_axis_tready = !next_final || q_room;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      size_last <= '0;
      col       <= '0;
      row       <= '0;
    end else if (cfg_wr_en) begin
      size_last <= cfg_size_last;
      col       <= '0;
      row       <= '0;
    end else if (s_accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : IDX_W'(row + 1'b1);
      end else begin
        col <= IDX_W'(col + 1'b1);
      end
    end
  end

  // Compute stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      fwd     <= 1'b0;
    end else begin
      b_valid <= s_accept;
      if (s_accept) fwd <= b_valid && (b_col == rd_addr);
    end
  end

  // Compute stage payload
  always_ff @(posedge clk) begin
    if (s_accept) begin
      b_cell      <= s_axis_tdata[CELL_WIDTH-1:0];
      b_col       <= col;
      b_first_row <= (row == '0);
      b_last_row  <= last_row;
      b_final     <= next_final;
      b_has_left  <= (col != '0);
      b_has_right <= !last_col;
      fwd_data    <= cost;
    end
  end

  // Row memory: read right neighbor on accept, write cost back
  always_ff @(posedge clk) begin
    if (s_accept) mem_q <= row_mem[rd_addr];
    if (b_valid)  row_mem[b_col] <= cost;
  end

  // Same-entry read and write in one cycle takes the fresh cost
  assign rd_value = fwd ? fwd_data : mem_q;

  // Slide the window: right neighbor becomes current, current becomes left
  always_ff @(posedge clk) begin
    if (b_valid) begin
      win_left <= win_cur;
      win_cur  <= rd_value;
    end
  end

  // Cell cost: cell plus the least of its neighbors in the row above; the first row takes the cell alone
  always_comb begin
    best = win_cur;
    if (b_has_left && (win_left < best)) best = win_left;
    if (b_has_right && (rd_value < best)) best = rd_value;
    if (b_first_row) cost = COST_W'(b_cell);
    else             cost = COST_W'(b_cell) + best;
  end

  // Running minimum over the last row
  assign rmin_new = ((b_col == '0) || (cost < rmin)) ? cost : rmin;

  always_ff @(posedge clk) begin
    if (rst) begin
      rmin <= '0;
    end else if (b_valid && b_last_row) begin
      rmin <= rmin_new;
    end
  end

  // Result: low bits of the sign-extended minimum
  assign rmin_ext    = EXT_W'(rmin_new);
  assign q_push      = b_valid && b_final;
  assign q_push_data = rmin_ext[mfps_pkg::SUM_WIDTH-1:0];

  mfps_result_q u_result_q (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .room      (q_room),
    .out_valid (m_axis_tvalid),
    .out_data  (q_data),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tdata = {{mfps_pkg::OUT_PAD{1'b0}}, q_data};

`ifndef SYNTHESIS
  // Counters stay inside the configured matrix
  assert property (@(posedge clk) disable iff (rst)
    (col <= size_last) && (row <= size_last))
    else $error("position counter beyond matrix size");

  // Forwarding is only needed for sizes of one or two
  assert property (@(posedge clk) disable iff (rst)
    (b_valid && fwd) |-> (size_last <= IDX_W'(1)))
    else $error("unexpected read/write collision on row memory");

  // A result appears only after a final cell was computed
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(q_push))
    else $error("result without a final cell");
`endif

endmodule

`default_nettype wire
